FILE: rtl/core/mi3_pkg.sv
// Shared types, widths and index tables for the 3x3 matrix inverse core.
`default_nettype none
package mi3_pkg;

  localparam int EW      = 32;          // element width
  localparam int FB      = 16;          // fractional bits
  localparam int NEL     = 9;           // elements per matrix
  localparam int NPROD   = 2 * NEL;     // 2x2 minor products
  localparam int COF_W   = 2 * EW + 1;  // cofactor width
  localparam int DET_W   = 3 * EW + 1;  // determinant width
  localparam int MAG_W   = DET_W - 1;   // determinant magnitude width
  localparam int QB      = EW;          // quotient bits resolved by the divider
  localparam int THR_W   = 32;          // threshold register width
  localparam int FRONT_LAT = 5;
  localparam int LANE_LAT  = QB + 3;
  localparam int SING_DLY  = LANE_LAT - 2;
  localparam int TOT_LAT   = FRONT_LAT + LANE_LAT;

  // cofactor k = e[MUL_L[2k]]*e[MUL_R[2k]] - e[MUL_L[2k+1]]*e[MUL_R[2k+1]]
  localparam int MUL_L [NPROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int MUL_R [NPROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  typedef logic signed [EW-1:0]    elem_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    elem_t a00; elem_t a01; elem_t a02;
    elem_t a10; elem_t a11; elem_t a12;
    elem_t a20; elem_t a21; elem_t a22;
  } in_t;

  typedef struct packed {
    elem_t b00; elem_t b01; elem_t b02;
    elem_t b10; elem_t b11; elem_t b12;
    elem_t b20; elem_t b21; elem_t b22;
    logic  singular;
    logic  saturated;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/core/mi3_front.sv
// Cofactor and determinant pipeline: minor products, cofactors, split det products.
`default_nettype none
module mi3_front (
  input  logic             clk,
  input  logic             en,
  input  mi3_pkg::in_t     a,
  output mi3_pkg::cof_t    cof [mi3_pkg::NEL],
  output mi3_pkg::det_t    det
);

  mi3_pkg::elem_t e [mi3_pkg::NEL];
  logic signed [2*mi3_pkg::EW-1:0] p_r [mi3_pkg::NPROD];
  mi3_pkg::elem_t a_r1 [3];
  mi3_pkg::elem_t a_r2 [3];
  mi3_pkg::cof_t  cof_r2 [mi3_pkg::NEL];
  mi3_pkg::cof_t  cof_r3 [mi3_pkg::NEL];
  mi3_pkg::cof_t  cof_r4 [mi3_pkg::NEL];
  mi3_pkg::cof_t  cof_r5 [mi3_pkg::NEL];
  logic signed [mi3_pkg::COF_W-1:0] plo_r [3];
  logic signed [mi3_pkg::COF_W-1:0] phi_r [3];
  mi3_pkg::det_t  prod_r [3];
  mi3_pkg::det_t  det_r;

  assign e[0] = a.a00; assign e[1] = a.a01; assign e[2] = a.a02;
  assign e[3] = a.a10; assign e[4] = a.a11; assign e[5] = a.a12;
  assign e[6] = a.a20; assign e[7] = a.a21; assign e[8] = a.a22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::NPROD; i++) begin
        p_r[i] <= e[mi3_pkg::MUL_L[i]] * e[mi3_pkg::MUL_R[i]];
      end
      for (int k = 0; k < 3; k++) begin
        a_r1[k] <= e[k];
        a_r2[k] <= a_r1[k];
      end
      for (int k = 0; k < mi3_pkg::NEL; k++) begin
        cof_r2[k] <= mi3_pkg::COF_W'(p_r[2*k]) - mi3_pkg::COF_W'(p_r[2*k+1]);
        cof_r3[k] <= cof_r2[k];
        cof_r4[k] <= cof_r3[k];
        cof_r5[k] <= cof_r4[k];
      end
      // det = a0*cof0 + a1*cof3 + a2*cof6; each product split at bit EW
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= a_r2[k] * signed'({1'b0, cof_r2[3*k][mi3_pkg::EW-1:0]});
        phi_r[k] <= a_r2[k] * signed'(cof_r2[3*k][mi3_pkg::COF_W-1:mi3_pkg::EW]);
        prod_r[k] <= (mi3_pkg::DET_W'(phi_r[k]) <<< mi3_pkg::EW) + mi3_pkg::DET_W'(plo_r[k]);
      end
      det_r <= prod_r[0] + prod_r[1] + prod_r[2];
    end
  end

  assign cof = cof_r5;
  assign det = det_r;

endmodule
`default_nettype wire

FILE: rtl/core/mi3_div_lane.sv
// One quotient lane: magnitudes, overflow test, radix-2 divider stages, sign and clip.
`default_nettype none
module mi3_div_lane (
  input  logic            clk,
  input  logic            en,
  input  mi3_pkg::cof_t   cof,
  input  mi3_pkg::det_t   det,
  output mi3_pkg::elem_t  elem,
  output logic            sat
);

  localparam int MW = mi3_pkg::MAG_W;
  localparam int QB = mi3_pkg::QB;

  mi3_pkg::cof_t  cof_neg;
  mi3_pkg::det_t  det_neg;
  logic [mi3_pkg::COF_W-2:0] cmag_r;
  logic [MW-1:0]  dmag_r;
  logic           neg_r;

  logic [MW-1:0]  r_s [QB+1];
  logic [MW-1:0]  d_s [QB+1];
  logic [QB-1:0]  q_s [QB+1];
  logic           n_s [QB+1];
  logic           o_s [QB+1];

  mi3_pkg::elem_t elem_r;
  logic           sat_r;

  assign cof_neg = -cof;
  assign det_neg = -det;

  always_ff @(posedge clk) begin
    if (en) begin
      cmag_r <= cof[mi3_pkg::COF_W-1] ? cof_neg[mi3_pkg::COF_W-2:0] : cof[mi3_pkg::COF_W-2:0];
      dmag_r <= det[mi3_pkg::DET_W-1] ? det_neg[MW-1:0] : det[MW-1:0];
      neg_r  <= cof[mi3_pkg::COF_W-1] ^ det[mi3_pkg::DET_W-1];
      // quotient reaches 2^QB exactly when |cof| >= |det|
      r_s[0] <= MW'(cmag_r);
      d_s[0] <= dmag_r;
      q_s[0] <= '0;
      n_s[0] <= neg_r;
      o_s[0] <= MW'(cmag_r) >= dmag_r;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [MW+1:0] diff;
    assign diff = {1'b0, r_s[i], 1'b0} - {2'b00, d_s[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i+1] <= diff[MW+1] ? {r_s[i][MW-2:0], 1'b0} : diff[MW-1:0];
        q_s[i+1] <= {q_s[i][QB-2:0], ~diff[MW+1]};
        d_s[i+1] <= d_s[i];
        n_s[i+1] <= n_s[i];
        o_s[i+1] <= o_s[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!n_s[QB]) begin
        if (o_s[QB] || q_s[QB][QB-1]) begin
          elem_r <= {1'b0, {(QB-1){1'b1}}};
          sat_r  <= 1'b1;
        end else begin
          elem_r <= q_s[QB];
          sat_r  <= 1'b0;
        end
      end else begin
        if (o_s[QB] || (q_s[QB][QB-1] && |q_s[QB][QB-2:0])) begin
          elem_r <= {1'b1, {(QB-1){1'b0}}};
          sat_r  <= 1'b1;
        end else begin
          elem_r <= -q_s[QB];
          sat_r  <= 1'b0;
        end
      end
    end
  end

  assign elem = elem_r;
  assign sat  = sat_r;

endmodule
`default_nettype wire

FILE: rtl/core/matrix_inverse_3x3_core.sv
// Top level: cofactor front end, nine divider lanes, singular test, merge and output buffer.
//
//  channel | signals                        | payload
//  --------+--------------------------------+-------------------------------
//  input   | in_valid / in_ready            | in_data  (a00..a22, Q16.16)
//  output  | out_valid / out_ready          | out_data (b00..b22, flags)
//  config  | cfg_we                         | cfg_data (singular_threshold)
//
// One request enters per cycle while the output buffer has room; each result is offered
// after 5 front-end stages and 35 divider-lane stages (32 of them one quotient bit each),
// then the output buffer write. The whole pipeline advances while the two-entry output
// buffer has room, so a request is still taken while one result waits. Synchronous reset
// clears the valid chain, buffer count and pointers and threshold; the datapath is not reset.
`default_nettype none
module matrix_inverse_3x3_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mi3_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mi3_pkg::out_t        out_data,
  input  logic                 cfg_we,
  input  logic [mi3_pkg::THR_W-1:0] cfg_data
);

  logic                        en;
  logic [mi3_pkg::THR_W-1:0]   thr;
  logic                        vld [mi3_pkg::TOT_LAT];
  mi3_pkg::cof_t               cof [mi3_pkg::NEL];
  mi3_pkg::det_t               det;
  mi3_pkg::det_t               det_neg;
  logic [mi3_pkg::MAG_W-1:0]   dmag;
  logic                        sing_t;
  logic                        sing_d [mi3_pkg::SING_DLY];
  mi3_pkg::elem_t              q [mi3_pkg::NEL];
  logic [mi3_pkg::NEL-1:0]     qsat;
  mi3_pkg::out_t               merged;
  mi3_pkg::out_t               obuf [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  cnt;
  logic                        push;
  logic                        pop;

  assign en       = (cnt != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mi3_pkg::TOT_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < mi3_pkg::TOT_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  mi3_front u_front (
    .clk (clk),
    .en  (en),
    .a   (in_data),
    .cof (cof),
    .det (det)
  );

  for (genvar k = 0; k < mi3_pkg::NEL; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cof  (cof[k]),
      .det  (det),
      .elem (q[k]),
      .sat  (qsat[k])
    );
  end

  // singular test, kept in step with the lanes
  assign det_neg = -det;
  always_ff @(posedge clk) begin
    if (en) begin
      dmag   <= det[mi3_pkg::DET_W-1] ? det_neg[mi3_pkg::MAG_W-1:0] : det[mi3_pkg::MAG_W-1:0];
      sing_t <= !(dmag > mi3_pkg::MAG_W'({thr, {mi3_pkg::FB{1'b0}}}));
      sing_d[0] <= sing_t;
      for (int i = 1; i < mi3_pkg::SING_DLY; i++) sing_d[i] <= sing_d[i-1];
    end
  end

  always_comb begin
    merged.b00 = q[0]; merged.b01 = q[1]; merged.b02 = q[2];
    merged.b10 = q[3]; merged.b11 = q[4]; merged.b12 = q[5];
    merged.b20 = q[6]; merged.b21 = q[7]; merged.b22 = q[8];
    merged.singular  = 1'b0;
    merged.saturated = |qsat;
    if (sing_d[mi3_pkg::SING_DLY-1]) begin
      merged = '0;
      merged.singular = 1'b1;
    end
  end

  assign push = en && vld[mi3_pkg::TOT_LAT-1];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) obuf[wr_ptr] <= merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign out_data  = obuf[rd_ptr];

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_stall_full: assert property (@(posedge clk) disable iff (rst) !in_ready |-> cnt == 2'd2)
    else $error("request stalled with buffer room");
  a_drain_frees: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && out_ready) |=> in_ready)
    else $error("buffer slot not freed after pop");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.singular) |-> (!out_data.saturated && out_data.b11 == '0))
    else $error("singular result not cleared");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the 3x3 adjugate matrix inverse core.
`timescale 1ns / 1ps
module tb;
  import mi3_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = TOT_LAT + 20;
  localparam int N_RANDOM       = 1300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;

  matrix_inverse_3x3_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_t  pending_mats[$];
  out_t expected_inv[$];
  logic [THR_W-1:0] thr_model = '0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   singular_seen = 0;
  int   saturated_seen = 0;
  int   idle_cycles = 0;
  bit   no_idle = 1'b0;
  bit   stim_done = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;

  // Exact quotient: cofactor * 2^32 / det, truncated toward zero, clipped.
  function automatic elem_t div_clip(input logic signed [COF_W-1:0] cof,
                                     input logic signed [DET_W-1:0] det,
                                     inout bit sat);
    logic [200:0] num_mag, den_mag, q;
    bit neg;
    num_mag = cof[COF_W-1] ? 201'(-cof) : 201'(cof);
    den_mag = det[DET_W-1] ? 201'(-det) : 201'(det);
    num_mag = num_mag << (2 * FB);
    neg = cof[COF_W-1] ^ det[DET_W-1];
    q = num_mag / den_mag;
    if (!neg) begin
      if (q >= 201'(64'h8000_0000)) begin
        sat = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      return elem_t'(q[EW-1:0]);
    end
    if (q > 201'(64'h8000_0000)) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return elem_t'(-q[EW:0]);
  endfunction

  function automatic out_t invert_matrix(input in_t m);
    logic signed [COF_W-1:0] c [9];
    logic signed [DET_W-1:0] det;
    logic signed [EW-1:0] e [9];
    logic [200:0] lhs, rhs;
    out_t r;
    bit sat;
    e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    c[0] = COF_W'(e[4]) * e[8] - COF_W'(e[5]) * e[7];
    c[1] = COF_W'(e[2]) * e[7] - COF_W'(e[1]) * e[8];
    c[2] = COF_W'(e[1]) * e[5] - COF_W'(e[2]) * e[4];
    c[3] = COF_W'(e[5]) * e[6] - COF_W'(e[3]) * e[8];
    c[4] = COF_W'(e[0]) * e[8] - COF_W'(e[2]) * e[6];
    c[5] = COF_W'(e[2]) * e[3] - COF_W'(e[0]) * e[5];
    c[6] = COF_W'(e[3]) * e[7] - COF_W'(e[4]) * e[6];
    c[7] = COF_W'(e[1]) * e[6] - COF_W'(e[0]) * e[7];
    c[8] = COF_W'(e[0]) * e[4] - COF_W'(e[1]) * e[3];
    det = DET_W'(e[0]) * c[0] + DET_W'(e[1]) * c[3] + DET_W'(e[2]) * c[6];
    lhs = (det[DET_W-1] ? 201'(-det) : 201'(det)) << 32;
    rhs = 201'(thr_model) << (3 * FB);
    r = '0;
    sat = 1'b0;
    if (lhs > rhs) begin
      r.b00 = div_clip(c[0], det, sat); r.b01 = div_clip(c[1], det, sat);
      r.b02 = div_clip(c[2], det, sat); r.b10 = div_clip(c[3], det, sat);
      r.b11 = div_clip(c[4], det, sat); r.b12 = div_clip(c[5], det, sat);
      r.b20 = div_clip(c[6], det, sat); r.b21 = div_clip(c[7], det, sat);
      r.b22 = div_clip(c[8], det, sat);
      r.saturated = sat;
    end else begin
      r.singular = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic compare_inverse(input out_t got, input out_t want);
    logic [EW-1:0] g [9], w [9];
    g = '{got.b00, got.b01, got.b02, got.b10, got.b11, got.b12,
          got.b20, got.b21, got.b22};
    w = '{want.b00, want.b01, want.b02, want.b10, want.b11, want.b12,
          want.b20, want.b21, want.b22};
    for (int k = 0; k < 9; k++)
      if (g[k] !== w[k]) report_mismatch($sformatf("b%0d%0d", k / 3, k % 3), g[k], w[k]);
    if (got.singular !== want.singular)
      report_mismatch("singular", got.singular, want.singular);
    if (got.saturated !== want.saturated)
      report_mismatch("saturated", got.saturated, want.saturated);
  endtask

  // Driver: hold each request until accepted, idle in bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else begin
      if (in_valid) begin
        expected_inv.push_back(invert_matrix(in_data));
        pending_mats.pop_front();
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_mats.size() > 0) begin
        in_data <= pending_mats[0];
        in_valid <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check results, random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_inv.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          compare_inverse(out_data, expected_inv.pop_front());
          results_seen++;
          singular_seen += out_data.singular;
          saturated_seen += out_data.saturated;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 9);
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return elem_t'($urandom_range(0, 8) - 4) <<< FB;
      3: return elem_t'($urandom);
      4: return elem_t'(int'($urandom_range(0, 1023)) - 512);
      default: return elem_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic in_t rand_matrix();
    in_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // make some rows dependent to hit zero and tiny determinants
    if ($urandom_range(0, 7) == 0) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  function automatic in_t diag(input elem_t d0, input elem_t d1, input elem_t d2);
    in_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  // Let the pipeline empty, then write the threshold.
  task automatic set_threshold(input logic [THR_W-1:0] v);
    wait (pending_mats.size() == 0 && !in_valid && expected_inv.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_model = v;
  endtask

  localparam elem_t ONE = 32'sh0001_0000;

  initial begin
    in_t m;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, zero, extremes, tiny and huge determinants
    pending_mats.push_back(diag(ONE, ONE, ONE));
    pending_mats.push_back('0);
    pending_mats.push_back(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_mats.push_back(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    pending_mats.push_back(diag(32'sh1, 32'sh1, 32'sh1));
    pending_mats.push_back(diag(32'sh1, ONE, ONE));
    pending_mats.push_back(diag(32'sh2, ONE, ONE));
    pending_mats.push_back(diag(-32'sh2, ONE, ONE));
    pending_mats.push_back(diag(ONE, -ONE, ONE));
    pending_mats.push_back(diag(ONE <<< 1, ONE <<< 2, -ONE));
    pending_mats.push_back('1);
    m = '1; m.a00 = ONE; m.a11 = ONE; m.a22 = ONE;
    pending_mats.push_back(m);
    m = {9{32'sh7FFF_FFFF}};
    pending_mats.push_back(m);
    m = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
         32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF};
    pending_mats.push_back(m);
    set_threshold(32'hFFFF_FFFF);
    pending_mats.push_back(diag(ONE, ONE, ONE));
    pending_mats.push_back(diag(ONE <<< 8, ONE <<< 8, ONE));
    pending_mats.push_back(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    set_threshold(32'h1);
    pending_mats.push_back(diag(32'sh1, ONE, ONE));
    pending_mats.push_back(diag(32'sh1, 32'sh1, ONE));

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_threshold(32'h0);
        1: set_threshold($urandom);
        2: set_threshold(32'h0000_0100);
        3: set_threshold(32'hFFFF_FFFF);
        default: set_threshold(32'h0);
      endcase
      if (phase == 4) no_idle = 1'b1;
      for (int i = 0; i < N_RANDOM / 5; i++) pending_mats.push_back(rand_matrix());
    end
    wait (pending_mats.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  initial begin
    int guard;
    guard = 0;
    wait (stim_done);
    while (expected_inv.size() != 0 && guard < WATCHDOG_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d inverses: %0d singular, %0d saturated, %0d mismatches",
             results_seen, singular_seen, saturated_seen, mismatches);
    $display("thresholds covered zero, one, mid, random and all ones");
    if (mismatches == 0 && expected_inv.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_div_lane.sv
rtl/core/matrix_inverse_3x3_core.sv
tb/tb.sv
